>>> src/apid_pkg.sv
package apid_pkg;

  // Fixed widths of the register file, the accumulated error and the drive.
  localparam int GAIN_W  = 32;
  localparam int POWER_W = 7;
  localparam int CDEG_W  = 16;
  localparam int LIMIT_W = 20;
  localparam int ESUM_W  = 21;
  localparam int DRIVE_W = 8;

  // Near-zone scaling by nine tenths: multiply by nine, then divide the
  // integer part by ten through a reciprocal that is exact below 2^16.
  localparam int NEAR_NUM    = 9;
  localparam int UNIT_W      = 11;
  localparam int DIV10_RECIP = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int DIV10_W     = UNIT_W + 16;

  // Register reset values.
  localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 32'd249981;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 32'd168;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 32'd452985;
  localparam logic [POWER_W-1:0] MAX_POWER_RST  = 7'd127;
  localparam logic [CDEG_W-1:0]  DEADBAND_RST   = 16'd200;
  localparam logic [LIMIT_W-1:0] INT_LIMIT_RST  = 20'd1500;
  localparam logic [CDEG_W-1:0]  NEAR_ZONE_RST  = 16'd1000;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    IDX_GAIN_P     = 3'd0,
    IDX_GAIN_I     = 3'd1,
    IDX_GAIN_D     = 3'd2,
    IDX_MAX_POWER  = 3'd3,
    IDX_DEADBAND   = 3'd4,
    IDX_INT_LIMIT  = 3'd5,
    IDX_NEAR_ZONE  = 3'd6
  } cfg_idx_e;

  localparam int CFG_IDX_W = 3;

  // Current register contents, shared by the error and product/sum stages.
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [POWER_W-1:0] max_power;
    logic [CDEG_W-1:0]  deadband;
    logic [LIMIT_W-1:0] int_limit;
    logic [CDEG_W-1:0]  near_zone;
  } cfg_t;

  // Per-word zone flags that travel down the pipeline.
  typedef struct packed {
    logic in_deadband;
    logic near;
  } flags_t;

endpackage

>>> src/arm_pid_position_controller_top.sv
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  target_cdeg, angle_cdeg
// m_axis   out  m_axis_tvalid/m_axis_tready  drive, at_target
// cfg      in   cfg_we_i (no wait)           cfg_index_i, cfg_wdata_i
//
// One word is accepted per clock while m_axis is not stalled; the pipeline has five
// register stages (input, error and integral, products, clamped sum, output), and each
// word passes through them in that order before its result is valid on m_axis.
// The integral loop closes in the error stage, one word per cycle when not stalled.
// Reset clears the handshake state, the integral, the previous error and the
// registers to their defaults. A stall on m_axis backs up stage by stage, so
// empty stages still take words while a result waits.
module arm_pid_position_controller_top import apid_pkg::*; #(
  parameter int ANGLE_WIDTH        = 24,
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [ANGLE_WIDTH-1:0] target_cdeg, [2*ANGLE_WIDTH-1:ANGLE_WIDTH] angle_cdeg, zero pad
  input  logic [((2*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] drive, [8] at_target, [15:9] zero
  output logic [15:0]          m_axis_tdata
);

  localparam int MW = POWER_W + GAIN_FRACTION_BITS;

  cfg_t                          cfg_q;
  logic                          err_valid, err_ready;
  logic signed [ANGLE_WIDTH:0]   err;
  logic signed [ESUM_W-1:0]      esum;
  logic signed [ANGLE_WIDTH+1:0] deriv;
  flags_t                        err_flags, mac_flags;
  logic                          mac_valid, mac_ready;
  logic [MW-1:0]                 mag;
  logic                          neg;
  logic signed [DRIVE_W-1:0]     drive;
  logic                          at_target;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p    <= GAIN_P_RST;
      cfg_q.gain_i    <= GAIN_I_RST;
      cfg_q.gain_d    <= GAIN_D_RST;
      cfg_q.max_power <= MAX_POWER_RST;
      cfg_q.deadband  <= DEADBAND_RST;
      cfg_q.int_limit <= INT_LIMIT_RST;
      cfg_q.near_zone <= NEAR_ZONE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        IDX_GAIN_P:    cfg_q.gain_p    <= cfg_wdata_i;
        IDX_GAIN_I:    cfg_q.gain_i    <= cfg_wdata_i;
        IDX_GAIN_D:    cfg_q.gain_d    <= cfg_wdata_i;
        IDX_MAX_POWER: cfg_q.max_power <= cfg_wdata_i[POWER_W-1:0];
        IDX_DEADBAND:  cfg_q.deadband  <= cfg_wdata_i[CDEG_W-1:0];
        IDX_INT_LIMIT: cfg_q.int_limit <= cfg_wdata_i[LIMIT_W-1:0];
        IDX_NEAR_ZONE: cfg_q.near_zone <= cfg_wdata_i[CDEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Error, derivative and integral stages.
  apid_error #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_error (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .target_i($signed(s_axis_tdata[ANGLE_WIDTH-1:0])),
    .angle_i ($signed(s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH])),
    .valid_o (err_valid),
    .ready_i (err_ready),
    .err_o   (err),
    .esum_o  (esum),
    .deriv_o (deriv),
    .flags_o (err_flags)
  );

  // Gain products and saturated sum.
  apid_mac #(
    .ANGLE_WIDTH       (ANGLE_WIDTH),
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .err_i   (err),
    .esum_i  (esum),
    .deriv_i (deriv),
    .flags_i (err_flags),
    .valid_o (mac_valid),
    .ready_i (mac_ready),
    .mag_o   (mag),
    .neg_o   (neg),
    .flags_o (mac_flags)
  );

  // Near-zone scaling, truncation and output register.
  apid_scale #(
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mac_valid),
    .ready_o    (mac_ready),
    .mag_i      (mag),
    .neg_i      (neg),
    .flags_i    (mac_flags),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .drive_o    (drive),
    .at_target_o(at_target)
  );

  assign m_axis_tdata = {7'd0, at_target, drive};

  // A word inside the deadband always carries zero drive.
  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("drive is not zero at target");

  // The drive never reaches the most negative code.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'h80))
    else $error("drive out of range");

  // With the output register empty, no stage can be blocked.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

endmodule

>>> src/apid_error.sv
module apid_error import apid_pkg::*; #(
  parameter int ANGLE_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [ANGLE_WIDTH-1:0] target_i,
  input  logic signed [ANGLE_WIDTH-1:0] angle_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [ANGLE_WIDTH:0]   err_o,
  output logic signed [ESUM_W-1:0]      esum_o,
  output logic signed [ANGLE_WIDTH+1:0] deriv_o,
  output flags_t                        flags_o
);

  localparam int EW = ANGLE_WIDTH + 1;
  localparam int DW = ANGLE_WIDTH + 2;
  localparam int TW = ((EW > ESUM_W) ? EW : ESUM_W) + 1;

  logic                   in_valid_q, in_valid_d;
  logic signed [EW-2:0]   target_q, angle_q;
  logic                   err_valid_q, err_valid_d;
  logic signed [EW-1:0]   err_q, err_d;
  logic signed [ESUM_W-1:0] esum_q, esum_d;
  logic signed [DW-1:0]   deriv_q, deriv_d;
  flags_t                 flags_q, flags_d;
  logic                   in_ready, err_ready, load_in, load_err;
  logic [EW-1:0]          aerr;
  logic signed [TW-1:0]   acc, lim, acc_clamped;

  // Two-stage handshake: input register, then error register.
  assign err_ready  = !err_valid_q || ready_i;
  assign in_ready   = !in_valid_q || err_ready;
  assign load_in    = valid_i && in_ready;
  assign load_err   = in_valid_q && err_ready;
  assign ready_o    = in_ready;
  assign in_valid_d = load_in ? 1'b1 : (err_ready ? 1'b0 : in_valid_q);
  assign err_valid_d = load_err ? 1'b1 : (ready_i ? 1'b0 : err_valid_q);

  // Error, its magnitude and the zone tests.
  always_comb begin
    err_d               = EW'(target_q) - EW'(angle_q);
    aerr                = err_d[EW-1] ? EW'(-err_d) : EW'(err_d);
    flags_d.in_deadband = aerr < EW'(cfg_i.deadband);
    flags_d.near        = aerr < EW'(cfg_i.near_zone);
    // err_q holds the previous error, so the derivative uses it directly.
    deriv_d             = DW'(err_d) - DW'(err_q);
  end

  // Accumulated error with anti-windup clamp; cleared inside the deadband.
  always_comb begin
    acc = TW'(esum_q) + TW'(err_d);
    lim = $signed(TW'(cfg_i.int_limit));
    if (acc > lim) begin
      acc_clamped = lim;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc;
    end
    esum_d = flags_d.in_deadband ? '0 : ESUM_W'(acc_clamped);
  end

  // Handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      err_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      err_valid_q <= err_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      target_q <= target_i;
      angle_q  <= angle_i;
    end
  end

  // Controller state: previous error and accumulated error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q  <= '0;
      esum_q <= '0;
    end else if (load_err) begin
      err_q  <= err_d;
      esum_q <= esum_d;
    end
  end

  // Derivative and flags travel with the error.
  always_ff @(posedge clk_i) begin
    if (load_err) begin
      deriv_q <= deriv_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = err_valid_q;
  assign err_o   = err_q;
  assign esum_o  = esum_q;
  assign deriv_o = deriv_q;
  assign flags_o = flags_q;

endmodule

>>> src/apid_mac.sv
module apid_mac import apid_pkg::*; #(
  parameter int ANGLE_WIDTH        = 24,
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfg_t                                  cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [ANGLE_WIDTH:0]           err_i,
  input  logic signed [ESUM_W-1:0]              esum_i,
  input  logic signed [ANGLE_WIDTH+1:0]         deriv_i,
  input  flags_t                                flags_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [POWER_W+GAIN_FRACTION_BITS-1:0] mag_o,
  output logic                                  neg_o,
  output flags_t                                flags_o
);

  localparam int EW  = ANGLE_WIDTH + 1;
  localparam int DW  = ANGLE_WIDTH + 2;
  localparam int GW  = GAIN_W + 1;
  localparam int PPW = EW + GW;
  localparam int PIW = ESUM_W + GW;
  localparam int PDW = DW + GW;
  localparam int PW  = PDW + 2;
  localparam int MW  = POWER_W + GAIN_FRACTION_BITS;

  logic                  prod_valid_q, prod_valid_d;
  logic signed [PPW-1:0] prod_p_q, prod_p_d;
  logic signed [PIW-1:0] prod_i_q, prod_i_d;
  logic signed [PDW-1:0] prod_d_q, prod_d_d;
  flags_t                prod_flags_q;
  logic                  clamp_valid_q, clamp_valid_d;
  logic [MW-1:0]         mag_q, mag_d;
  logic                  neg_q, neg_d;
  flags_t                clamp_flags_q;
  logic                  prod_ready, clamp_ready, load_prod, load_clamp;
  logic signed [PW-1:0]  total, cap;

  // Two-stage handshake: products, then clamped sum.
  assign clamp_ready   = !clamp_valid_q || ready_i;
  assign prod_ready    = !prod_valid_q || clamp_ready;
  assign load_prod     = valid_i && prod_ready;
  assign load_clamp    = prod_valid_q && clamp_ready;
  assign ready_o       = prod_ready;
  assign prod_valid_d  = load_prod ? 1'b1 : (clamp_ready ? 1'b0 : prod_valid_q);
  assign clamp_valid_d = load_clamp ? 1'b1 : (ready_i ? 1'b0 : clamp_valid_q);

  // Three exact products with the unsigned gains.
  assign prod_p_d = err_i * $signed({1'b0, cfg_i.gain_p});
  assign prod_i_d = esum_i * $signed({1'b0, cfg_i.gain_i});
  assign prod_d_d = deriv_i * $signed({1'b0, cfg_i.gain_d});

  // Exact PID sum, saturated to the power limit, split into sign and magnitude.
  always_comb begin
    total = PW'(prod_p_q) + PW'(prod_i_q) + PW'(prod_d_q);
    cap   = $signed(PW'(cfg_i.max_power) << GAIN_FRACTION_BITS);
    if (total > cap) begin
      mag_d = MW'(cap);
      neg_d = 1'b0;
    end else if (total < -cap) begin
      mag_d = MW'(cap);
      neg_d = 1'b1;
    end else begin
      mag_d = total[PW-1] ? MW'(-total) : MW'(total);
      neg_d = total[PW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q  <= 1'b0;
      clamp_valid_q <= 1'b0;
    end else begin
      prod_valid_q  <= prod_valid_d;
      clamp_valid_q <= clamp_valid_d;
    end
  end

  // Product registers.
  always_ff @(posedge clk_i) begin
    if (load_prod) begin
      prod_p_q     <= prod_p_d;
      prod_i_q     <= prod_i_d;
      prod_d_q     <= prod_d_d;
      prod_flags_q <= flags_i;
    end
  end

  // Clamped sum registers.
  always_ff @(posedge clk_i) begin
    if (load_clamp) begin
      mag_q         <= mag_d;
      neg_q         <= neg_d;
      clamp_flags_q <= prod_flags_q;
    end
  end

  assign valid_o = clamp_valid_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;
  assign flags_o = clamp_flags_q;

endmodule

>>> src/apid_scale.sv
module apid_scale import apid_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [POWER_W+GAIN_FRACTION_BITS-1:0] mag_i,
  input  logic                                  neg_i,
  input  flags_t                                flags_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [DRIVE_W-1:0]             drive_o,
  output logic                                  at_target_o
);

  localparam int MW = POWER_W + GAIN_FRACTION_BITS;
  localparam int NW = MW + 4;

  logic                      valid_q, valid_d, load;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  logic                      at_target_q;
  logic [NW-1:0]             nine_m;
  logic [UNIT_W-1:0]         units;
  logic [DIV10_W-1:0]        tenth_prod;
  logic [DRIVE_W-1:0]        q;

  // Output register handshake.
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  // Truncate toward zero; in the near zone take nine tenths with one truncation.
  always_comb begin
    nine_m     = NW'(mag_i) * NW'(NEAR_NUM);
    units      = nine_m[NW-1:GAIN_FRACTION_BITS];
    tenth_prod = DIV10_W'(units) * DIV10_W'(DIV10_RECIP);
    if (flags_i.near) begin
      q = DRIVE_W'(tenth_prod[DIV10_W-1:DIV10_SHIFT]);
    end else begin
      q = DRIVE_W'(mag_i[MW-1:GAIN_FRACTION_BITS]);
    end
    if (flags_i.in_deadband) begin
      drive_d = '0;
    end else begin
      drive_d = neg_i ? $signed(-q) : $signed(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      drive_q     <= drive_d;
      at_target_q <= flags_i.in_deadband;
    end
  end

  assign valid_o     = valid_q;
  assign drive_o     = drive_q;
  assign at_target_o = at_target_q;

endmodule
